/* design/ate_pkg.sv */
// ----------------------------------------------------------------------------
// ate_pkg
// shared types and codes for the advertiser table
// ----------------------------------------------------------------------------
package ate_pkg;

  localparam logic [1:0] KIND_HDR  = 2'd0;
  localparam logic [1:0] KIND_BYTE = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  localparam logic [2:0] ST_HIT     = 3'd0;
  localparam logic [2:0] ST_INSERT  = 3'd1;
  localparam logic [2:0] ST_REPLACE = 3'd2;
  localparam logic [2:0] ST_TAKEN   = 3'd3;
  localparam logic [2:0] ST_IGNORED = 3'd4;
  localparam logic [2:0] ST_READ    = 3'd5;
  localparam logic [2:0] ST_RANGE   = 3'd6;

  localparam logic [7:0] AD_NAME_SHORT    = 8'h08;
  localparam logic [7:0] AD_NAME_COMPLETE = 8'h09;

  // one queued item as the back end sees it
  typedef struct packed {
    logic [1:0]  kind;
    logic [47:0] mac;
    logic [7:0]  peer_type;
    logic [7:0]  rssi;
    logic [31:0] time_ms;
    logic [7:0]  adv_length;
    logic [7:0]  data_byte;
    logic [5:0]  entry_index;
    logic [4:0]  name_offset;
  } item_t;

endpackage

/* design/ate_front.sv */
// ----------------------------------------------------------------------------
// ate_front
// accepts items and holds them in a two-deep queue for the back end
// ----------------------------------------------------------------------------
module ate_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ate_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output ate_pkg::item_t head
);
  import ate_pkg::*;

  item_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("push into full queue");
  assert property (@(posedge clk) disable iff (rst) !(pop && !not_empty))
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("queue count overflow");

endmodule

/* design/ate_back.sv */
// ----------------------------------------------------------------------------
// ate_back
// carries out one item at a time: lookup/evict sweep, parsing, reads
// ----------------------------------------------------------------------------
module ate_back #(
  parameter int ENTRIES    = 16,
  parameter int NAME_BYTES = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           avail,
  input  ate_pkg::item_t item,
  output logic           pop,
  output logic           strobe,
  output logic [2:0]     status,
  output logic [5:0]     slot_index,
  output logic [6:0]     entry_count,
  output logic [47:0]    entry_mac,
  output logic [7:0]     entry_addr_type,
  output logic [7:0]     entry_rssi,
  output logic [31:0]    entry_last_seen,
  output logic [4:0]     entry_name_length,
  output logic [7:0]     entry_name_byte
);
  import ate_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int NW = $clog2(NAME_BYTES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [4:0] NAME_MAX = 5'(NAME_BYTES - 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCAN  = 7'b0000010,
    S_HDR   = 7'b0000100,
    S_BYTE  = 7'b0001000,
    S_COPY  = 7'b0010000,
    S_READ  = 7'b0100000,
    S_READ2 = 7'b1000000
  } state_t;

  typedef enum logic [1:0] {PH_LEN, PH_TYPE, PH_DATA, PH_DONE} phase_t;

  state_t state;
  item_t  cur;

  logic [47:0] addr_mem  [ENTRIES];
  logic [7:0]  atype_mem [ENTRIES];
  logic [7:0]  rssi_mem  [ENTRIES];
  logic [31:0] time_mem  [ENTRIES];
  logic [4:0]  nlen_mem  [ENTRIES];
  logic [7:0]  name_mem  [ENTRIES * (1 << NW)];
  logic [7:0]  pend_mem  [NAME_BYTES];

  logic [CW-1:0] valid_count;
  logic [IW-1:0] open_slot;
  logic [7:0]    bytes_left;
  phase_t        phase;
  logic [7:0]    sbytes_left;
  logic [7:0]    stype;
  logic [4:0]    pend_len;

  logic [CW-1:0] scan_i;
  logic          hit;
  logic [IW-1:0] hit_slot;
  logic [IW-1:0] old_slot;
  logic [31:0]   old_time;
  logic [4:0]    copy_i;
  logic [7:0]    name_rd;

  logic [IW-1:0] scan_idx;
  logic [IW-1:0] rd_idx;
  logic [7:0]    left_dec;
  logic [7:0]    sleft_dec;
  logic          finish;
  logic          is_name;

  function automatic logic is_name_next(logic [7:0] b);
    return (b == AD_NAME_SHORT) || (b == AD_NAME_COMPLETE);
  endfunction

  assign scan_idx  = scan_i[IW-1:0];
  assign rd_idx    = cur.entry_index[IW-1:0];
  assign left_dec  = bytes_left - 8'd1;
  assign sleft_dec = sbytes_left - 8'd1;
  assign is_name   = (stype == AD_NAME_SHORT) || (stype == AD_NAME_COMPLETE);
  assign pop       = (state == S_IDLE) && avail;

  always_ff @(posedge clk) begin
    name_rd <= name_mem[{rd_idx, cur.name_offset[NW-1:0]}];
  end

  always_comb begin
    finish = 1'b0;
    if (phase == PH_TYPE) finish = (sleft_dec == 8'd0) && is_name_next(cur.data_byte);
    else if (phase == PH_DATA) finish = (sleft_dec == 8'd0) && is_name;
  end

  always_ff @(posedge clk) begin
    logic strobe_next;
    strobe_next = 1'b0;
    if (rst) begin
      state       <= S_IDLE;
      valid_count <= '0;
      open_slot   <= '0;
      bytes_left  <= 8'd0;
      phase       <= PH_LEN;
      sbytes_left <= 8'd0;
      stype       <= 8'd0;
      pend_len    <= 5'd0;
    end else begin
      unique case (state)
        S_IDLE: if (avail) begin
          cur               <= item;
          entry_mac         <= '0;
          entry_addr_type   <= '0;
          entry_rssi        <= '0;
          entry_last_seen   <= '0;
          entry_name_length <= '0;
          entry_name_byte   <= '0;
          scan_i            <= '0;
          hit               <= 1'b0;
          hit_slot          <= '0;
          old_slot          <= '0;
          old_time          <= '1;
          case (item.kind)
            KIND_HDR:  state <= S_SCAN;
            KIND_BYTE: state <= S_BYTE;
            KIND_READ: state <= S_READ;
            default:   state <= S_BYTE;
          endcase
        end
        // one entry per cycle: match among valid, oldest among all
        S_SCAN: begin
          if (!hit && scan_i < valid_count && addr_mem[scan_idx] == cur.mac) begin
            hit      <= 1'b1;
            hit_slot <= scan_idx;
          end
          if (scan_i == '0 || time_mem[scan_idx] < old_time) begin
            old_slot <= scan_idx;
            old_time <= time_mem[scan_idx];
          end
          if (scan_i == CW'(ENTRIES - 1)) state <= S_HDR;
          scan_i <= scan_i + 1'b1;
        end
        S_HDR: begin
          logic [IW-1:0] s;
          logic [2:0]    st;
          s  = hit_slot;
          st = ST_HIT;
          if (!hit) begin
            if (valid_count < CW'(ENTRIES)) begin
              s  = valid_count[IW-1:0];
              st = ST_INSERT;
              valid_count <= valid_count + 1'b1;
            end else begin
              s  = old_slot;
              st = ST_REPLACE;
            end
            addr_mem[s] <= cur.mac;
            nlen_mem[s] <= 5'd0;
          end
          atype_mem[s] <= cur.peer_type;
          rssi_mem[s]  <= cur.rssi;
          time_mem[s]  <= cur.time_ms;
          open_slot    <= s;
          bytes_left   <= cur.adv_length;
          phase        <= PH_LEN;
          sbytes_left  <= 8'd0;
          stype        <= 8'd0;
          pend_len     <= 5'd0;
          strobe_next  = 1'b1;
          status       <= st;
          slot_index   <= 6'(s);
          entry_count  <= 7'(valid_count + ((!hit && st == ST_INSERT) ? 1'b1 : 1'b0));
          state        <= S_IDLE;
        end
        S_BYTE: begin
          strobe_next = 1'b1;
          entry_count <= 7'(valid_count);
          if (cur.kind == KIND_BYTE && bytes_left != 8'd0) begin
            status     <= ST_TAKEN;
            slot_index <= 6'(open_slot);
            bytes_left <= left_dec;
            case (phase)
              PH_LEN:
                if (cur.data_byte == 8'd0 || cur.data_byte > left_dec) phase <= PH_DONE;
                else begin
                  sbytes_left <= cur.data_byte;
                  phase       <= PH_TYPE;
                end
              PH_TYPE: begin
                stype       <= cur.data_byte;
                pend_len    <= 5'd0;
                sbytes_left <= sleft_dec;
                phase       <= (sleft_dec == 8'd0) ? PH_LEN : PH_DATA;
              end
              PH_DATA: begin
                if (pend_len < NAME_MAX) begin
                  pend_mem[pend_len[NW-1:0]] <= cur.data_byte;
                  pend_len <= pend_len + 5'd1;
                end
                sbytes_left <= sleft_dec;
                if (sleft_dec == 8'd0) phase <= PH_LEN;
              end
              default: ;
            endcase
            // a closing name structure holds the result until the copy ends
            state <= finish ? S_COPY : S_IDLE;
            if (finish) begin
              copy_i      <= 5'd0;
              strobe_next = 1'b0;
            end
          end else begin
            status     <= ST_IGNORED;
            slot_index <= 6'd0;
            state      <= S_IDLE;
          end
        end
        // copy pending name into the entry one byte per cycle
        S_COPY: begin
          if (copy_i < pend_len)
            name_mem[{open_slot, copy_i[NW-1:0]}] <= pend_mem[copy_i[NW-1:0]];
          copy_i <= copy_i + 5'd1;
          if (copy_i >= pend_len) begin
            nlen_mem[open_slot] <= pend_len;
            strobe_next = 1'b1;
            state  <= S_IDLE;
          end
        end
        S_READ: state <= S_READ2;
        S_READ2: begin
          strobe_next = 1'b1;
          slot_index  <= cur.entry_index;
          entry_count <= 7'(valid_count);
          state       <= S_IDLE;
          if (7'(cur.entry_index) < 7'(valid_count)) begin
            status            <= ST_READ;
            entry_mac         <= addr_mem[rd_idx];
            entry_addr_type   <= atype_mem[rd_idx];
            entry_rssi        <= rssi_mem[rd_idx];
            entry_last_seen   <= time_mem[rd_idx];
            entry_name_length <= nlen_mem[rd_idx];
            if (cur.name_offset < nlen_mem[rd_idx]) entry_name_byte <= name_rd;
          end else status <= ST_RANGE;
        end
        default: state <= S_IDLE;
      endcase
    end
    strobe <= strobe_next;
  end

  assert property (@(posedge clk) disable iff (rst) valid_count <= CW'(ENTRIES))
    else $error("entry count beyond table");
  assert property (@(posedge clk) disable iff (rst) strobe |-> $past(state) != S_IDLE)
    else $error("result without work");
  assert property (@(posedge clk) disable iff (rst) pop |=> state != S_IDLE)
    else $error("popped item not taken");

endmodule

/* design/advertiser_table_oldest_evict.sv */
// ----------------------------------------------------------------------------
// advertiser_table_oldest_evict
// table of advertisers with name parsing and oldest-entry eviction
// ----------------------------------------------------------------------------
// usage: raise start with kind and payload; the item is taken when busy is
// low. each item yields exactly one result, shown for one cycle with strobe.
// a front queue (two items) takes items while the back end works, so busy
// only rises when the queue is full.
// steps: a header runs a match/oldest sweep over the table, one entry per
// cycle, then the update; a byte is parsed, and when a name structure
// closes its name is copied into the entry before the result; a read waits
// on the registered name memory read. the back end is the limit on rate.
// reset: synchronous rst empties the queue, clears the entry count and
// closes any open report. stores are not cleared; only written entries are
// ever read. the receiver cannot stall: results must be taken when strobed.
// ----------------------------------------------------------------------------
module advertiser_table_oldest_evict #(
  parameter int ENTRIES    = 16,
  parameter int NAME_BYTES = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind,
  input  logic [47:0] mac,
  input  logic [7:0]  peer_type,
  input  logic signed [7:0] rssi,
  input  logic [31:0] time_ms,
  input  logic [7:0]  adv_length,
  input  logic [7:0]  data_byte,
  input  logic [5:0]  entry_index,
  input  logic [4:0]  name_offset,
  output logic        strobe,
  output logic [2:0]  status,
  output logic [5:0]  slot_index,
  output logic [6:0]  entry_count,
  output logic [47:0] entry_mac,
  output logic [7:0]  entry_addr_type,
  output logic signed [7:0] entry_rssi,
  output logic [31:0] entry_last_seen,
  output logic [4:0]  entry_name_length,
  output logic [7:0]  entry_name_byte
);
  import ate_pkg::*;

  item_t in_item;
  item_t head;
  logic  full;
  logic  not_empty;
  logic  pop;
  logic [7:0] rssi_u;

  // pack the ports into one queue entry
  assign in_item = '{kind: kind, mac: mac, peer_type: peer_type, rssi: rssi,
                     time_ms: time_ms, adv_length: adv_length,
                     data_byte: data_byte, entry_index: entry_index,
                     name_offset: name_offset};
  assign busy       = full;
  assign entry_rssi = rssi_u;

  ate_front u_front (
    .clk(clk), .rst(rst), .push(start && !full), .push_item(in_item),
    .full(full), .pop(pop), .not_empty(not_empty), .head(head)
  );

  ate_back #(.ENTRIES(ENTRIES), .NAME_BYTES(NAME_BYTES)) u_back (
    .clk(clk), .rst(rst), .avail(not_empty), .item(head), .pop(pop),
    .strobe(strobe), .status(status), .slot_index(slot_index),
    .entry_count(entry_count), .entry_mac(entry_mac),
    .entry_addr_type(entry_addr_type), .entry_rssi(rssi_u),
    .entry_last_seen(entry_last_seen), .entry_name_length(entry_name_length),
    .entry_name_byte(entry_name_byte)
  );

endmodule
